/* hdl/pwli_pkg.sv */
// Shared types and constants for the piecewise-linear table interpolator.
// No dependencies; used by pwli_ctrl, pwli_dp and the top level.
package pwli_pkg;

  localparam int POINTS    = 64;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 7;
  localparam int STEP_W    = 7;
  localparam int MUL_STEPS = 33;
  localparam int DIV_STEPS = 66;

  // read address source for the node memories
  typedef enum logic [1:0] {
    RD_MID = 2'd0,
    RD_LO  = 2'd1,
    RD_HI  = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load_wr;
    logic    start;
    logic    search_step;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    latch0;
    logic    latch1;
    logic    prep;
    logic    mul_step;
    logic    div_init;
    logic    div_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic seg_bad;
    logic out_valid;
  } sts_t;

endpackage

/* hdl/pwli_dp.sv */
// Datapath: node memories, search bounds, serial multiplier and divider,
// result register. Depends on pwli_pkg.
module pwli_dp import pwli_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic [ADDR_W-1:0] in_index,
  input  logic [DATA_W-1:0] in_node_x,
  input  logic [DATA_W-1:0] in_node_y,
  input  logic [DATA_W-1:0] in_query_x,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_value,
  output logic              out_saturated,
  output logic              out_bad
);

  logic [CNT_W-1:0]  point_count;
  logic [ADDR_W-1:0] last_idx;
  logic [DATA_W-1:0] x_mem [POINTS];
  logic [DATA_W-1:0] y_mem [POINTS];
  logic [DATA_W-1:0] rd_x, rd_y;
  logic [DATA_W-1:0] qx, x0, y0, x1, y1;
  logic [ADDR_W-1:0] lo, hi, mid, rd_addr;
  logic [CNT_W-1:0]  mid_sum;
  logic [DATA_W:0]   dx, dy, dn, mag_dx_c, mag_dy_c, mag_dn_c;
  logic [DATA_W:0]   mag_dx, mag_dn;
  logic              neg;
  logic [65:0]       prod, dvd;
  logic [33:0]       psum, trial;
  logic              ge;
  logic [DATA_W:0]   rem;
  logic [34:0]       quo;
  logic              ovf, big;
  logic [34:0]       sum, q_ext;
  logic              too_hi, too_lo;
  logic [DATA_W-1:0] res_value;
  logic              res_sat;
  logic              out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CNT_W'(2);
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  // last usable index: count clamped to 2..POINTS, minus one
  always_comb begin
    if (point_count < CNT_W'(2)) begin
      last_idx = ADDR_W'(1);
    end else if (point_count > CNT_W'(POINTS)) begin
      last_idx = ADDR_W'(POINTS - 1);
    end else begin
      last_idx = ADDR_W'(point_count - CNT_W'(1));
    end
  end

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W-1:1];

  always_comb begin
    unique case (cmd.rd_sel)
      RD_MID:  rd_addr = mid;
      RD_LO:   rd_addr = lo;
      RD_HI:   rd_addr = lo + ADDR_W'(1);
      default: rd_addr = lo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      x_mem[in_index] <= in_node_x;
      y_mem[in_index] <= in_node_y;
    end
    if (cmd.rd_en) begin
      rd_x <= x_mem[rd_addr];
      rd_y <= y_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx <= in_query_x;
      lo <= '0;
      hi <= last_idx;
    end else if (cmd.search_step) begin
      if ($signed(rd_x) <= $signed(qx)) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.latch0) begin
      x0 <= rd_x;
      y0 <= rd_y;
    end
    if (cmd.latch1) begin
      x1 <= rd_x;
      y1 <= rd_y;
    end
  end

  assign sts.search_done = (hi - lo) <= ADDR_W'(1);
  assign sts.seg_bad     = (x0 == x1);

  assign dx = {qx[DATA_W-1], qx} - {x1[DATA_W-1], x1};
  assign dy = {y0[DATA_W-1], y0} - {y1[DATA_W-1], y1};
  assign dn = {x0[DATA_W-1], x0} - {x1[DATA_W-1], x1};
  assign mag_dx_c = dx[DATA_W] ? -dx : dx;
  assign mag_dy_c = dy[DATA_W] ? -dy : dy;
  assign mag_dn_c = dn[DATA_W] ? -dn : dn;

  // shift-add multiply, then restoring divide
  assign psum  = {1'b0, prod[65:33]} + {1'b0, mag_dx};
  assign trial = {rem, dvd[65]};
  assign ge    = trial >= {1'b0, mag_dn};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      mag_dx <= mag_dx_c;
      mag_dn <= mag_dn_c;
      neg    <= dx[DATA_W] ^ dy[DATA_W] ^ dn[DATA_W];
      prod   <= {33'd0, mag_dy_c};
    end else if (cmd.mul_step) begin
      prod <= prod[0] ? {psum, prod[32:1]} : {1'b0, prod[65:1]};
    end
    if (cmd.div_init) begin
      dvd <= prod;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[64:0], 1'b0};
      rem <= ge ? 33'(trial - {1'b0, mag_dn}) : trial[32:0];
      quo <= {quo[33:0], ge};
      ovf <= ovf | quo[34];
    end
  end

  // quotient above 2^33 saturates outright
  assign big    = ovf | quo[34] | (quo[33] & (|quo[32:0]));
  assign q_ext  = {1'b0, quo[33:0]};
  assign sum    = {{3{y1[DATA_W-1]}}, y1} + (neg ? -q_ext : q_ext);
  assign too_hi = !sum[34] && (|sum[33:31]);
  assign too_lo = sum[34] && !(&sum[33:31]);

  always_comb begin
    res_sat   = 1'b0;
    res_value = sum[DATA_W-1:0];
    if (sts.seg_bad) begin
      res_value = y1;
    end else if (big) begin
      res_sat   = 1'b1;
      res_value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (too_hi) begin
      res_sat   = 1'b1;
      res_value = 32'h7FFF_FFFF;
    end else if (too_lo) begin
      res_sat   = 1'b1;
      res_value = 32'h8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value     <= res_value;
      out_saturated <= res_sat;
      out_bad       <= sts.seg_bad;
    end
  end

  assign sts.out_valid = out_valid;

endmodule

/* hdl/pwli_ctrl.sv */
// Controller state machine: sequences search, node fetch, multiply, divide
// and result hand-off. Depends on pwli_pkg.
module pwli_ctrl import pwli_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SRD   = 11'b000_0000_0010,
    S_SCMP  = 11'b000_0000_0100,
    S_F0    = 11'b000_0000_1000,
    S_F1    = 11'b000_0001_0000,
    S_F2    = 11'b000_0010_0000,
    S_PREP  = 11'b000_0100_0000,
    S_MUL   = 11'b000_1000_0000,
    S_DINIT = 11'b001_0000_0000,
    S_DIV   = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  state_t           state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic             slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !sts.out_valid || out_ready;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.rd_sel = RD_MID;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            cmd.start  = 1'b1;
            state_next = S_SRD;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_SRD: begin
        if (sts.search_done) begin
          state_next = S_F0;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.search_step = 1'b1;
        state_next      = S_SRD;
      end
      S_F0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LO;
        state_next = S_F1;
      end
      S_F1: begin
        cmd.latch0 = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HI;
        state_next = S_F2;
      end
      S_F2: begin
        cmd.latch1 = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        step_next = '0;
        if (sts.seg_bad) begin
          state_next = S_FIN;
        end else begin
          cmd.prep   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(MUL_STEPS - 1)) begin
          state_next = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

`ifndef ASSERT_OFF
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> state == S_IDLE)
    else $error("controller not idle after reset");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!sts.out_valid || out_ready))
    else $error("result register overwritten while held");
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step == STEP_W'(DIV_STEPS - 1)) |=> state == S_FIN)
    else $error("divide did not finish");
  a_mul_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && step == STEP_W'(MUL_STEPS - 1)) |=> state == S_DINIT)
    else $error("multiply did not finish");
`endif

endmodule

/* hdl/piecewise_linear_table_interp.sv */
// Top level of the piecewise-linear table interpolator.
// Depends on pwli_pkg, pwli_ctrl and pwli_dp.
//
// Usage:
//   Requests arrive on the s_axis channel. tuser = kind: 0 writes one table
//   point (point_index, node_x, node_y), 1 is a query at query_x. Loads give
//   no result. A query gives one result on m_axis: value (Q16.16), tuser[0] =
//   saturated, tuser[1] = bad_segment. The user must write point_count through
//   cfg_we/cfg_wdata only while the block idles; the block does not enforce it.
// Sequence:
//   Binary search with a read state and a compare state per probe (up to 6),
//   a last visit to the read state to see it done, three node-fetch states,
//   prep, a 33-step shift-add multiply, divider set-up, a 66-step restoring
//   divide and a final state that loads the result and raises m_axis_tvalid;
//   equal segment x skips the multiply and the divide. One request is in work
//   at a time; the next is taken the cycle after.
// Reset: rst (synchronous) empties the output register, point_count = 2.
//   Node memories are not cleared; load them before querying.
// Stall: a finished result waits in the output register; the next request
//   can be taken meanwhile, but its result waits until the slot frees.
module piecewise_linear_table_interp import pwli_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [5:0] point_index, [37:6] node_x, [69:38] node_y, [101:70] query_x, pad
  input  logic [103:0] s_axis_tdata,
  // [0] kind
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] value
  output logic [31:0]  m_axis_tdata,
  // [0] saturated, [1] bad_segment
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  pwli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_kind   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pwli_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_index      (s_axis_tdata[5:0]),
    .in_node_x     (s_axis_tdata[37:6]),
    .in_node_y     (s_axis_tdata[69:38]),
    .in_query_x    (s_axis_tdata[101:70]),
    .out_ready     (m_axis_tready),
    .out_value     (m_axis_tdata),
    .out_saturated (m_axis_tuser[0]),
    .out_bad       (m_axis_tuser[1])
  );

  assign m_axis_tvalid = sts.out_valid;

endmodule

/* tb/tb.sv */
// Self-checking bench for piecewise_linear_table_interp: table loads, queries, point_count.
// Depends on pwli_pkg and the RTL under hdl/; reads no files.
module tb;
  import pwli_pkg::*;

  localparam bit KIND_LOAD  = 1'b0;
  localparam bit KIND_QUERY = 1'b1;
  localparam int ITEM_GOAL  = 1600;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT = 160;

  typedef enum int {TBL_RAMP, TBL_FLAT, TBL_WIDE, TBL_RANDOM} table_shape_t;

  typedef struct {
    int   value;
    bit   sat;
    bit   bad;
  } interp_result_t;

  // Mirror of the block: node store, point count and queue of interpolations in flight.
  class interp_scoreboard;
    int             x_tab[POINTS];
    int             y_tab[POINTS];
    bit [6:0]       count_reg;
    interp_result_t pending_q[$];
    int             errors, loads, queries, sat_seen, bad_seen;

    function new();
      count_reg = 7'd2;
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    static function longint unsigned magnitude(longint d);
      return d < 0 ? longint'(-d) : longint'(d);
    endfunction

    // Segment search and exact interpolation for one query x.
    function interp_result_t interpolate(int qx);
      interp_result_t res;
      int n, lo, hi, mid;
      longint x, x0, x1, y0, y1, dx, dy, dn, r;
      longint unsigned q;
      bit neg;
      n = count_reg;
      if (n < 2) n = 2;
      if (n > POINTS) n = POINTS;
      x = qx;
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (x_tab[mid] <= qx) lo = mid;
        else hi = mid;
      end
      x0 = x_tab[lo];
      x1 = x_tab[lo + 1];
      y0 = y_tab[lo];
      y1 = y_tab[lo + 1];
      res.sat = 0;
      res.bad = 0;
      if (x0 == x1) begin
        res.value = int'(y1);
        res.bad = 1;
        return res;
      end
      dx = x - x1;
      dy = y0 - y1;
      dn = x0 - x1;
      neg = ((dx < 0) != (dy < 0)) != (dn < 0);
      if (dx == 0 || dy == 0) neg = 0;
      q = (magnitude(dx) * magnitude(dy)) / magnitude(dn);
      if (q > 64'h2_0000_0000) begin
        r = neg ? -64'sd2147483648 : 64'sd2147483647;
        res.sat = 1;
      end else begin
        r = y1 + (neg ? -longint'(q) : longint'(q));
        if (r > 64'sd2147483647) begin
          r = 64'sd2147483647;
          res.sat = 1;
        end else if (r < -64'sd2147483648) begin
          r = -64'sd2147483648;
          res.sat = 1;
        end
      end
      res.value = int'(r);
      return res;
    endfunction

    function void note_request(bit kind, bit [5:0] idx, int nx, int ny, int qx);
      if (kind == KIND_LOAD) begin
        x_tab[idx] = nx;
        y_tab[idx] = ny;
        loads++;
      end else begin
        pending_q = {pending_q, interpolate(qx)};
        queries++;
      end
    endfunction

    task check_result(bit [31:0] value, bit [1:0] flags);
      interp_result_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result value=%h flags=%b", value, flags));
        return;
      end
      e = pending_q.pop_front();
      if (value !== e.value)
        report($sformatf("value got %h want %h", value, e.value));
      if (flags[0] !== e.sat)
        report($sformatf("saturated got %b want %b (value %h)", flags[0], e.sat, e.value));
      if (flags[1] !== e.bad)
        report($sformatf("bad_segment got %b want %b", flags[1], e.bad));
      sat_seen += e.sat;
      bad_seen += e.bad;
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we;
  logic [6:0]   cfg_wdata;

  interp_scoreboard sb;
  bit     no_idle;         // stretch where neither side idles
  int     results_seen;
  longint cycle_count;

  piecewise_linear_table_interp u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Monitors: sample handshakes on the edge, before any update lands.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_request(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[37:6],
                      s_axis_tdata[69:38], s_axis_tdata[101:70]);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
      results_seen++;
    end
  end

  // Result side: random backpressure, one long hold-off so the block fills up
  // and stalls its input while requests keep coming.
  initial begin
    bit held;
    held = 0;
    m_axis_tready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1;
        m_axis_tready <= 0;
        repeat (700) @(posedge clk);
      end
      m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 23);
      @(posedge clk);
    end
  end

  // Timeout guard.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d results pending",
                 cycle_count, sb.pending_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one request; the handshake is judged from tready at the falling edge,
  // which holds through the next rising edge. Returns at the accepting edge with
  // tvalid still up; the next request or the caller drops it.
  task automatic send_request(bit kind, bit [5:0] idx, int nx, int ny, int qx);
    bit took;
    if (!no_idle)
      while ($urandom_range(99) < 23) begin
        s_axis_tvalid <= 0;
        @(posedge clk);
      end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, qx, ny, nx, idx};
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic load_point(bit [5:0] idx, int nx, int ny);
    send_request(KIND_LOAD, idx, nx, ny, $urandom);
  endtask

  task automatic query(int qx);
    send_request(KIND_QUERY, 6'($urandom), $urandom, $urandom, qx);
  endtask

  // Stop offering and wait for the next edge so the last accepted request is noted.
  task automatic stop_requests();
    s_axis_tvalid <= 0;
    @(posedge clk);
  endtask

  // Write point_count only when no result is outstanding and the datapath has settled.
  task automatic set_point_count(bit [6:0] cnt);
    stop_requests();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we    <= 0;
    sb.count_reg = cnt;
  endtask

  function automatic int node_x_for(table_shape_t shape, int i, int prev);
    case (shape)
      TBL_RAMP:   return (i == 0) ? -int'($urandom_range(1 << 24)) :
                                    prev + int'($urandom_range(1 << 20, 1));
      TBL_FLAT:   return (i == 0) ? -int'($urandom_range(1 << 24)) :
                                    prev + (($urandom_range(3) == 0) ? 0 :
                                            int'($urandom_range(1 << 18, 1)));
      TBL_WIDE:   return -2147483647 - 1 + i * 67108863;
      default:    return $urandom;
    endcase
  endfunction

  function automatic int node_y_for(table_shape_t shape, int i);
    if (shape == TBL_WIDE)
      return i[0] ? 32'h7fff_ffff : 32'h8000_0000;
    return ($urandom_range(3) == 0) ? $urandom : int'($urandom_range(1 << 22)) - (1 << 21);
  endfunction

  // Fill all slots, so no query can ever touch an unwritten node.
  task automatic fill_table(table_shape_t shape);
    int prev;
    prev = 0;
    for (int i = 0; i < POINTS; i++) begin
      prev = node_x_for(shape, i, prev);
      load_point(6'(i), prev, node_y_for(shape, i));
    end
  endtask

  function automatic int pick_query_x();
    int k, base;
    k = $urandom_range(99);
    if (k < 5)  return 32'h8000_0000;
    if (k < 10) return 32'h7fff_ffff;
    if (k < 25) return $urandom;
    base = sb.x_tab[$urandom_range(POINTS - 1)];
    if (k < 35) return base;
    return base + int'($urandom_range(1 << 19)) - (1 << 18);
  endfunction

  initial begin
    bit [6:0] counts[8];
    table_shape_t shape;
    int items, phase;
    counts = '{7'd2, 7'd64, 7'd127, 7'd0, 7'd1, 7'd65, 7'd17, 7'd33};
    sb = new();
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 0;
    cfg_we        = 0;
    cfg_wdata     = '0;
    no_idle       = 0;
    results_seen  = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: sorted ramp, queries at extremes, on nodes and past both ends.
    fill_table(TBL_RAMP);
    set_point_count(7'd64);
    query(32'h8000_0000);
    query(32'h7fff_ffff);
    query(sb.x_tab[0]);
    query(sb.x_tab[63]);
    query(sb.x_tab[31] + 1);
    query(sb.x_tab[0] - 1);
    // equal segment x and overflow on a steep segment
    load_point(6'd5, 1000, 32'h7fff_ffff);
    load_point(6'd6, 1000, 32'h8000_0000);
    load_point(6'd7, 1001, 32'h7fff_ffff);
    query(1000);
    query(999);
    query(1001);
    query(sb.x_tab[8]);
    query(32'h7fff_ffff);
    // count below minimum and above table size
    set_point_count(7'd0);
    query(32'h8000_0000);
    query(32'h7fff_ffff);
    set_point_count(7'd127);
    query(32'h7fff_ffff);
    query(0);

    items = sb.loads + sb.queries;
    phase = 0;
    while (items < ITEM_GOAL) begin
      shape = table_shape_t'(phase % 4);
      no_idle = (phase == 2);
      set_point_count(phase < 8 ? counts[phase] : 7'($urandom_range(127)));
      fill_table(shape);
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(99) < 15) begin
          // overwrite in place; sorted shapes keep their x and stay sorted
          int slot;
          slot = $urandom_range(POINTS - 1);
          load_point(6'(slot), (shape == TBL_RANDOM) ? int'($urandom) : sb.x_tab[slot],
                     node_y_for(shape, slot));
        end else
          query(pick_query_x());
      end
      items = sb.loads + sb.queries;
      phase++;
    end

    stop_requests();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d loads and %0d queries over %0d table phases;",
             sb.loads, sb.queries, phase);
    $display("%0d saturated and %0d equal-x results, %0d mismatches.",
             sb.sat_seen, sb.bad_seen, sb.errors);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* piecewise_linear_table_interp.f */
hdl/pwli_pkg.sv
hdl/pwli_dp.sv
hdl/pwli_ctrl.sv
hdl/piecewise_linear_table_interp.sv
tb/tb.sv
